>>> rtl/core/lp2c_pkg.sv
// shared constants, arctangent table and pipeline word type for the polar to cartesian block
package lp2c_pkg;

	// rotation stages and output fraction bits
	localparam int CORDIC_STAGES = 16;
	localparam int FRACTION_BITS = 8;

	// datapath widths
	localparam int ANGLE_W = 16;
	localparam int DIST_W = 18;
	localparam int QUAL_W = 8;
	localparam int Z_W = 16;
	localparam int OUT_W = 25;
	localparam int MAG_W = 16;
	localparam int GAIN_W = 24;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int XW = 44;
	localparam int AW = 33;

	// cordic gain compensation in q24
	localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;

	// arctangent of 2^-i, 2^32 units per turn
	localparam int ATAN_COUNT = 24;
	localparam logic [31:0] ATAN_TABLE [ATAN_COUNT] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	// word carried down the rotation pipeline
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [AW-1:0] acc;
		logic signed [Z_W-1:0] z;
	} rot_t;

endpackage

>>> rtl/core/lidar_polar_to_cartesian.sv
// Lidar sample to cartesian point converter. Takes one sample word per clock
// while the output is not stalled and returns x = d*cos, y = d*sin (d = range
// truncated to whole mm) with 8 fraction bits, rounded to nearest and saturated,
// plus the scan height. Samples with zero range or zero quality are consumed and
// give no point. The quadrant fold and gain multiply, every one of the 16 cordic
// stages and the output rounding each end in a register. Every stage has its own
// valid bit and a stall propagates back only through full stages, so the
// sustained rate is one sample per cycle while the output is not stalled.
module lidar_polar_to_cartesian (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lp2c_pkg::ANGLE_W-1:0]      angle_units,
	input  logic [lp2c_pkg::DIST_W-1:0]       distance_quarter_mm,
	input  logic [lp2c_pkg::QUAL_W-1:0]       quality,
	input  logic signed [lp2c_pkg::Z_W-1:0]   level_z_mm,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lp2c_pkg::OUT_W-1:0] x_fixed,
	output logic signed [lp2c_pkg::OUT_W-1:0] y_fixed,
	output logic signed [lp2c_pkg::Z_W-1:0]   point_z_mm
);
	import lp2c_pkg::*;

	logic prep_valid;
	logic prep_ready;
	rot_t prep_word;
	logic rot_valid;
	logic rot_ready;
	rot_t rot_word;

	// fold and scale
	lp2c_prep u_prep (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.angle_units         (angle_units),
		.distance_quarter_mm (distance_quarter_mm),
		.quality             (quality),
		.level_z_mm          (level_z_mm),
		.prep_valid          (prep_valid),
		.prep_ready          (prep_ready),
		.prep_word           (prep_word)
	);

	// rotation pipeline
	lp2c_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.prep_valid (prep_valid),
		.prep_ready (prep_ready),
		.prep_word  (prep_word),
		.rot_valid  (rot_valid),
		.rot_ready  (rot_ready),
		.rot_word   (rot_word)
	);

	// rounding and output register
	lp2c_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.rot_valid  (rot_valid),
		.rot_ready  (rot_ready),
		.rot_word   (rot_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.x_fixed    (x_fixed),
		.y_fixed    (y_fixed),
		.point_z_mm (point_z_mm)
	);

endmodule

>>> rtl/core/lp2c_prep.sv
// first stage: range truncation, sample filter, quadrant fold and gain scaling
module lp2c_prep (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lp2c_pkg::ANGLE_W-1:0]   angle_units,
	input  logic [lp2c_pkg::DIST_W-1:0]    distance_quarter_mm,
	input  logic [lp2c_pkg::QUAL_W-1:0]    quality,
	input  logic signed [lp2c_pkg::Z_W-1:0] level_z_mm,
	output logic                           prep_valid,
	input  logic                           prep_ready,
	output lp2c_pkg::rot_t                 prep_word
);
	import lp2c_pkg::*;

	logic [MAG_W-1:0] dist_mm;
	logic keep;
	logic flip;
	logic [PROD_W-1:0] prod;
	logic signed [XW-1:0] mag;
	rot_t word_next;
	logic valid_s1;
	rot_t word_s1;

	// truncate to whole millimetres and drop empty or invalid samples
	assign dist_mm = distance_quarter_mm[DIST_W-1:2];
	assign keep = (dist_mm != '0) && (quality != '0);

	// quadrants one and two start from the negative x axis
	assign flip = angle_units[ANGLE_W-1] ^ angle_units[ANGLE_W-2];
	assign prod = PROD_W'(dist_mm) * PROD_W'(GAIN_Q24);
	assign mag = signed'(XW'(prod));

	always_comb begin
		word_next.x = flip ? -mag : mag;
		word_next.y = '0;
		// residual angle is the low 15 bits taken as signed, scaled to 2^32 per turn
		word_next.acc = {{(AW-31){angle_units[ANGLE_W-2]}}, angle_units[ANGLE_W-2:0], 16'b0};
		word_next.z = level_z_mm;
	end

	assign in_ready = !valid_s1 || prep_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready) begin
			word_s1 <= word_next;
		end
	end

	assign prep_valid = valid_s1;
	assign prep_word = word_s1;

endmodule

>>> rtl/core/lp2c_cordic.sv
// unrolled rotation-mode cordic, one registered stage per iteration
module lp2c_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           prep_valid,
	output logic           prep_ready,
	input  lp2c_pkg::rot_t prep_word,
	output logic           rot_valid,
	input  logic           rot_ready,
	output lp2c_pkg::rot_t rot_word
);
	import lp2c_pkg::*;

	rot_t st_sn [CORDIC_STAGES];
	logic v_sn [CORDIC_STAGES];
	logic rdy [CORDIC_STAGES+1];

	assign rdy[CORDIC_STAGES] = rot_ready;
	assign prep_ready = rdy[0];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		rot_t prv;
		logic prv_v;
		rot_t nxt;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [AW-1:0] step;

		if (i == 0) begin : g_first
			assign prv = prep_word;
			assign prv_v = prep_valid;
		end else begin : g_next
			assign prv = st_sn[i-1];
			assign prv_v = v_sn[i-1];
		end

		// stage advances when empty or when the next one moves
		assign rdy[i] = !v_sn[i] || rdy[i+1];

		// micro-rotation toward zero residual angle
		assign dx = $signed(prv.y) >>> i;
		assign dy = $signed(prv.x) >>> i;
		assign step = signed'({1'b0, ATAN_TABLE[i]});

		always_comb begin
			nxt.z = prv.z;
			if (!prv.acc[AW-1]) begin
				nxt.x = prv.x - dx;
				nxt.y = prv.y + dy;
				nxt.acc = prv.acc - step;
			end else begin
				nxt.x = prv.x + dx;
				nxt.y = prv.y - dy;
				nxt.acc = prv.acc + step;
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_sn[i] <= prv_v;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				st_sn[i] <= nxt;
			end
		end
	end

	assign rot_valid = v_sn[CORDIC_STAGES-1];
	assign rot_word = st_sn[CORDIC_STAGES-1];

endmodule

>>> rtl/core/lp2c_round.sv
// output stage: round to nearest, saturate and hold the result word
module lp2c_round (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rot_valid,
	output logic                             rot_ready,
	input  lp2c_pkg::rot_t                   rot_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [lp2c_pkg::OUT_W-1:0] x_fixed,
	output logic signed [lp2c_pkg::OUT_W-1:0] y_fixed,
	output logic signed [lp2c_pkg::Z_W-1:0]   point_z_mm
);
	import lp2c_pkg::*;

	localparam int SH = 24 - FRACTION_BITS;
	localparam logic signed [XW-1:0] HALF = XW'(1) <<< (SH - 1);
	localparam logic signed [XW-1:0] OUT_MAX = XW'(16777215);
	localparam logic signed [XW-1:0] OUT_MIN = -XW'(16777216);

	logic out_valid_q;
	logic signed [OUT_W-1:0] x_q;
	logic signed [OUT_W-1:0] y_q;
	logic signed [Z_W-1:0] z_q;

	// round half up then clamp to the output range
	function automatic logic signed [OUT_W-1:0] sat_round(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = (v + HALF) >>> SH;
		if (r > OUT_MAX) begin
			r = OUT_MAX;
		end else if (r < OUT_MIN) begin
			r = OUT_MIN;
		end
		return r[OUT_W-1:0];
	endfunction

	assign rot_ready = !out_valid_q || out_ready;

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rot_ready) begin
			out_valid_q <= rot_valid;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (rot_ready) begin
			x_q <= sat_round(rot_word.x);
			y_q <= sat_round(rot_word.y);
			z_q <= rot_word.z;
		end
	end

	assign out_valid = out_valid_q;
	assign x_fixed = x_q;
	assign y_fixed = y_q;
	assign point_z_mm = z_q;

endmodule

>>> rtl/core/lp2c_checker.sv
// port-level checks for the polar to cartesian block, bound to the top level
module lp2c_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [lp2c_pkg::OUT_W-1:0] x_fixed,
	input logic signed [lp2c_pkg::OUT_W-1:0] y_fixed,
	input logic signed [lp2c_pkg::Z_W-1:0]   point_z_mm
);
	import lp2c_pkg::*;

	// a stalled result word holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_fixed) && $stable(y_fixed)
			&& $stable(point_z_mm))
		else $error("result word changed while stalled");

	// reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result word present during reset");

	// input back-pressure only when every stage is full behind a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled output");

	// an idle output never blocks the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!out_valid) && !in_valid |=> in_ready || out_valid)
		else $error("input blocked behind an empty output");

endmodule

bind lidar_polar_to_cartesian lp2c_checker u_lp2c_checker (.*);
